/* rtl/core/dshot_telemetry_decoder_core_macros.svh */
// assertion macros for the dshot telemetry decoder core
// used by the files that carry concurrent assertions
`ifndef DSHOT_TELEMETRY_DECODER_CORE_MACROS_SVH
`define DSHOT_TELEMETRY_DECODER_CORE_MACROS_SVH
// implication checked on every clock, held off in reset
`define DTD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define DTD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/core/dtd_pkg.sv */
// package for the dshot telemetry decoder: types, constants, gcr table
// no dependencies
`timescale 1ns / 1ps
package dtd_pkg;
  localparam int CaptureSymbols = 48;
  localparam int PulseMax = 2 * CaptureSymbols;
  localparam int PiW = $clog2(PulseMax + 1);
  localparam logic [6:0] EchoMax = 7'd96;
  localparam logic [4:0] FrameBits = 5'd21;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NOREPLY = 3'd1;
  localparam logic [2:0] ST_FRAMING = 3'd2;
  localparam logic [2:0] ST_BADGCR = 3'd3;
  localparam logic [2:0] ST_BADCS = 3'd4;

  localparam logic [2:0] TK_NONE = 3'd0;
  localparam logic [2:0] TK_ERPM = 3'd1;
  localparam logic [2:0] TK_TEMP = 3'd2;
  localparam logic [2:0] TK_VOLT = 3'd3;
  localparam logic [2:0] TK_AMP = 3'd4;
  localparam logic [2:0] TK_OTHER = 3'd5;

  localparam logic CFG_PERIOD = 1'b0;
  localparam logic CFG_GAP = 1'b1;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0, PH_BITS = 2'd1, PH_DECIDED = 2'd2, PH_DRAIN = 2'd3
  } phase_t;

  // divider request and reply between sequencer and divider
  typedef struct packed {
    logic        start;
    logic [25:0] num;
    logic [25:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [25:0] quo;
  } div_rsp_t;

  function automatic logic [4:0] gcr_nibble(input logic [4:0] q);
    case (q)
      5'h09: return 5'h09; 5'h0A: return 5'h0A; 5'h0B: return 5'h0B;
      5'h0D: return 5'h0D; 5'h0E: return 5'h0E; 5'h0F: return 5'h0F;
      5'h12: return 5'h02; 5'h13: return 5'h03; 5'h15: return 5'h05;
      5'h16: return 5'h06; 5'h17: return 5'h07; 5'h19: return 5'h00;
      5'h1A: return 5'h08; 5'h1B: return 5'h01; 5'h1D: return 5'h04;
      5'h1E: return 5'h0C;
      default: return 5'h10;
    endcase
  endfunction
endpackage

/* rtl/core/dtd_divider.sv */
// restoring divider, one quotient bit per cycle, 26 bit operands
// depends on dtd_pkg
`timescale 1ns / 1ps
`include "dshot_telemetry_decoder_core_macros.svh"
module dtd_divider import dtd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [25:0] den, quo, rem;
  logic [4:0]  cnt;
  logic        busy, done;
  logic [26:0] trial;

  assign trial = {rem, quo[25]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        den <= req.den;
        quo <= req.num;
        rem <= '0;
        cnt <= 5'd0;
      end else if (busy) begin
        if (!trial[26]) begin
          rem <= trial[25:0];
          quo <= {quo[24:0], 1'b1};
        end else begin
          rem <= {rem[24:0], quo[25]};
          quo <= {quo[24:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd25) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign rsp = {done, quo};

  `DTD_ASSERT_NXT(a_done_from_busy, clk, rst, rsp.done, !busy)
  `DTD_ASSERT_IMP(a_no_start_busy, clk, rst, busy && !req.start, cnt <= 5'd25)
  `DTD_ASSERT_NXT(a_start_busy, clk, rst, req.start, busy && cnt == 5'd0)
endmodule

/* rtl/core/dshot_telemetry_decoder_core.sv */
// dshot telemetry decoder: one captured pulse per word, one result per capture
// a pulse turned into bits takes a rounding divide, any other word none;
// a result follows its closing word via S_END and S_OUT, behind any divide of that
// word and any erpm divide; one word at a time, rate set by the shared divider
// a capture end waits while the previous result is still held
// synchronous reset restores the config registers and clears capture state; no clearing pass
`timescale 1ns / 1ps
`include "dshot_telemetry_decoder_core_macros.svh"
module dshot_telemetry_decoder_core import dtd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        pulse_level,
  input  logic [14:0] pulse_duration,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [6:0]  echo_pulses,
  output logic [2:0]  telem_kind,
  output logic [15:0] period_us,
  output logic [25:0] erpm,
  output logic [7:0]  edt_value
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_PDIV = 5'b00010, S_END = 5'b00100,
    S_EDIV = 5'b01000, S_OUT = 5'b10000
  } seq_t;

  seq_t        seq;
  logic [15:0] bit_period_q8;
  logic [14:0] gap_min_ticks;
  phase_t      phase;
  logic [6:0]  echo_count;
  logic [4:0]  bit_count;
  logic [20:0] shift_bits;
  logic [2:0]  error_code;
  logic [PiW-1:0] pulse_index;
  logic        lvl, ends, last;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic [15:0] q;
  logic [15:0] per_r;

  dtd_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign q = (bit_period_q8 == 16'd0) ? 16'd1 : bit_period_q8;
  assign in_stall = (seq != S_IDLE);

  // frame decode, combinational on the shift register
  logic [20:0] v;
  logic [19:0] g;
  logic [4:0]  m3, m2, m1, m0;
  logic [15:0] d16;
  logic [3:0]  cs;
  logic [11:0] d12;
  logic [3:0]  ty;
  logic [15:0] per;
  always_comb begin
    v = shift_bits << (FrameBits - bit_count);
    g = v[19:0] ^ v[20:1];
    m3 = gcr_nibble(g[19:15]);
    m2 = gcr_nibble(g[14:10]);
    m1 = gcr_nibble(g[9:5]);
    m0 = gcr_nibble(g[4:0]);
    d16 = {m3[3:0], m2[3:0], m1[3:0], m0[3:0]};
    cs = d16[15:12] ^ d16[11:8] ^ d16[7:4] ^ d16[3:0];
    d12 = d16[15:4];
    ty = d12[11:8];
    per = 16'({7'd0, d12[8:0]} << d12[11:9]);
  end

  logic [4:0] n, room;
  logic [25:0] nq;
  always_comb begin
    nq = drsp.quo;
    room = FrameBits - bit_count;
    if (nq == 26'd0) n = 5'd1;
    else if (nq > {21'd0, room}) n = room;
    else n = nq[4:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= S_IDLE;
      bit_period_q8 <= 16'd27306;
      gap_min_ticks <= 15'd332;
      phase <= PH_SEARCH;
      echo_count <= '0;
      bit_count <= '0;
      shift_bits <= '0;
      error_code <= '0;
      pulse_index <= '0;
      out_valid <= 1'b0;
      dreq.start <= 1'b0;
    end else begin
      dreq.start <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_PERIOD) bit_period_q8 <= cfg_data;
        else gap_min_ticks <= cfg_data[14:0];
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (seq)
        S_IDLE: if (in_valid && !in_stall) begin
          lvl <= pulse_level;
          last <= is_last;
          ends <= is_last || pulse_duration == 15'd0;
          seq <= S_END;
          if (phase == PH_DRAIN) begin
            ends <= 1'b0;
            if (is_last) begin
              phase <= PH_SEARCH; echo_count <= '0; bit_count <= '0;
              shift_bits <= '0; error_code <= '0; pulse_index <= '0;
            end
          end else if (pulse_index < PiW'(PulseMax)) begin
            pulse_index <= pulse_index + 1'b1;
            if (phase == PH_SEARCH && pulse_duration != 15'd0) begin
              if (pulse_level && pulse_duration >= gap_min_ticks) phase <= PH_BITS;
              else if (echo_count < EchoMax) echo_count <= echo_count + 7'd1;
            end else if (phase == PH_BITS && pulse_duration != 15'd0) begin
              if (bit_count == 5'd0 && pulse_level) begin
                error_code <= ST_FRAMING;
                phase <= PH_DECIDED;
              end else begin
                dreq.start <= 1'b1;
                dreq.num <= {3'd0, pulse_duration, 8'd0} + {11'd0, q[15:1]};
                dreq.den <= {10'd0, q};
                seq <= S_PDIV;
              end
            end
          end
        end
        S_PDIV: if (drsp.done) begin
          shift_bits <= 21'((shift_bits << n) | (lvl ? 21'd0 : ((21'd1 << n) - 21'd1)));
          bit_count <= bit_count + n;
          if (bit_count + n >= FrameBits) phase <= PH_DECIDED;
          seq <= S_END;
        end
        S_END: begin
          if (!ends) seq <= S_IDLE;
          // the result registers are reused once the previous word has left
          else if (!out_valid) begin
            echo_pulses <= echo_count;
            telem_kind <= TK_NONE;
            period_us <= '0;
            erpm <= '0;
            edt_value <= '0;
            seq <= S_OUT;
            if (phase == PH_SEARCH || (error_code == ST_OK && bit_count == 5'd0))
              status <= ST_NOREPLY;
            else if (error_code != ST_OK) status <= error_code;
            else if (m3[4] | m2[4] | m1[4] | m0[4]) status <= ST_BADGCR;
            else if (cs != 4'hF) status <= ST_BADCS;
            else begin
              status <= ST_OK;
              if (ty != 4'd0 && !ty[0]) begin
                edt_value <= d12[7:0];
                if (ty == 4'h2) telem_kind <= TK_TEMP;
                else if (ty == 4'h4) telem_kind <= TK_VOLT;
                else if (ty == 4'h6) telem_kind <= TK_AMP;
                else telem_kind <= TK_OTHER;
              end else begin
                telem_kind <= TK_ERPM;
                if (d12 != 12'hFFF) begin
                  period_us <= per;
                  per_r <= per;
                  if (per != 16'd0) begin
                    dreq.start <= 1'b1;
                    dreq.num <= 26'd60000000;
                    dreq.den <= {10'd0, per};
                    seq <= S_EDIV;
                  end
                end
              end
            end
          end
        end
        S_EDIV: if (drsp.done) begin
          erpm <= drsp.quo;
          seq <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          seq <= S_IDLE;
          if (last) begin
            phase <= PH_SEARCH; echo_count <= '0; bit_count <= '0;
            shift_bits <= '0; error_code <= '0; pulse_index <= '0;
          end else phase <= PH_DRAIN;
        end
        default: seq <= S_IDLE;
      endcase
    end
  end

  `DTD_ASSERT_IMP(a_bits_bound, clk, rst, 1'b1, bit_count <= FrameBits)
  `DTD_ASSERT_IMP(a_echo_bound, clk, rst, 1'b1, echo_count <= EchoMax)
  `DTD_ASSERT_NXT(a_edv_per, clk, rst, seq == S_EDIV, per_r != 16'd0)
endmodule

/* dv/dshot_telemetry_decoder_core_test.sv */
// self-checking testbench for dshot_telemetry_decoder_core: directed table then random captures
// depends on dtd_pkg and the core; predicts each capture result and compares word by word
`timescale 1ns / 1ps
module dshot_telemetry_decoder_core_test;
  import dtd_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        pulse_level;
  logic [14:0] pulse_duration;
  logic        is_last;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status;
  logic [6:0]  echo_pulses;
  logic [2:0]  telem_kind;
  logic [15:0] period_us;
  logic [25:0] erpm;
  logic [7:0]  edt_value;

  dshot_telemetry_decoder_core dut (.*);

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  echo;
    logic [2:0]  kind;
    logic [15:0] period;
    logic [25:0] erpm;
    logic [7:0]  edt;
  } telem_t;

  typedef struct packed {
    logic        level;
    logic [14:0] dur;
    logic        last;
    logic        chk;   // typed-in expectation present
    telem_t      res;
  } row_t;

  // decoder model state
  logic [15:0] period_q8;
  logic [14:0] gap_min;
  phase_t      cap_phase;
  logic [6:0]  cap_echo;
  logic [4:0]  cap_bits;
  logic [20:0] cap_shift;
  logic [2:0]  cap_err;
  int          cap_pulses;

  telem_t expected_q[$];
  int     errors;
  bit     idle_on;
  int     n_results;

  function automatic logic [4:0] quintet_nibble(input logic [4:0] q);
    logic [4:0] lut [32];
    lut = '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10,
            5'h10, 5'h09, 5'h0A, 5'h0B, 5'h10, 5'h0D, 5'h0E, 5'h0F,
            5'h10, 5'h10, 5'h02, 5'h03, 5'h10, 5'h05, 5'h06, 5'h07,
            5'h10, 5'h00, 5'h08, 5'h01, 5'h10, 5'h04, 5'h0C, 5'h10};
    return lut[q];
  endfunction

  function automatic void clear_capture();
    cap_phase = PH_SEARCH; cap_echo = 0; cap_bits = 0;
    cap_shift = 0; cap_err = 0; cap_pulses = 0;
  endfunction

  function automatic telem_t decode_reply();
    telem_t r;
    logic [20:0] v;
    logic [19:0] g;
    logic [4:0] n3, n2, n1, n0;
    logic [15:0] d16;
    logic [7:0] cs;
    logic [11:0] d12;
    logic [3:0] ty;
    logic [31:0] per;
    r = '0;
    r.echo = cap_echo;
    v = cap_shift;
    if (cap_bits < FrameBits) v = v << (FrameBits - cap_bits);
    g = 20'(v ^ (v >> 1));
    n3 = quintet_nibble(g[19:15]); n2 = quintet_nibble(g[14:10]);
    n1 = quintet_nibble(g[9:5]);   n0 = quintet_nibble(g[4:0]);
    if (n3[4] | n2[4] | n1[4] | n0[4]) begin
      r.status = ST_BADGCR;
      return r;
    end
    d16 = {n3[3:0], n2[3:0], n1[3:0], n0[3:0]};
    cs = d16[15:8] ^ d16[7:0];
    if ((cs[7:4] ^ cs[3:0]) != 4'hF) begin
      r.status = ST_BADCS;
      return r;
    end
    r.status = ST_OK;
    d12 = d16[15:4];
    ty = d12[11:8];
    if (ty != 0 && !ty[0]) begin
      case (ty)
        4'h2: r.kind = TK_TEMP;
        4'h4: r.kind = TK_VOLT;
        4'h6: r.kind = TK_AMP;
        default: r.kind = TK_OTHER;
      endcase
      r.edt = d12[7:0];
      return r;
    end
    r.kind = TK_ERPM;
    if (d12 != 12'hFFF) begin
      per = {23'd0, d12[8:0]} << d12[11:9];
      r.period = per[15:0];
      r.erpm = per != 0 ? 26'(32'd60000000 / per) : 26'd0;
    end
    return r;
  endfunction

  // returns 1 when the word closes a capture
  function automatic bit predict_pulse(input logic lvl, input logic [14:0] dur,
                                       input logic last, output telem_t r);
    logic [31:0] q, n;
    r = '0;
    if (cap_phase == PH_DRAIN) begin
      if (last) clear_capture();
      return 0;
    end
    if (cap_pulses < PulseMax) begin
      cap_pulses++;
      if (cap_phase == PH_SEARCH && dur != 0) begin
        if (lvl && dur >= gap_min) cap_phase = PH_BITS;
        else if (cap_echo < EchoMax) cap_echo++;
      end else if (cap_phase == PH_BITS && dur != 0) begin
        if (cap_bits == 0 && lvl) begin
          cap_err = ST_FRAMING;
          cap_phase = PH_DECIDED;
        end else begin
          q = period_q8 != 0 ? period_q8 : 1;
          n = ({17'd0, dur} * 256 + (q >> 1)) / q;
          if (n == 0) n = 1;
          if (cap_bits + n > FrameBits) n = FrameBits - cap_bits;
          cap_shift = (cap_shift << n) | (lvl ? 21'd0 : 21'((32'd1 << n) - 1));
          cap_bits += 5'(n);
          if (cap_bits >= FrameBits) cap_phase = PH_DECIDED;
        end
      end
    end
    if (!(last || dur == 0)) return 0;
    if (cap_phase == PH_SEARCH || (cap_err == 0 && cap_bits == 0)) begin
      r.status = ST_NOREPLY; r.echo = cap_echo;
    end else if (cap_err != 0) begin
      r.status = cap_err; r.echo = cap_echo;
    end else r = decode_reply();
    if (last) clear_capture();
    else cap_phase = PH_DRAIN;
    return 1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic send_pulse(input logic lvl, input logic [14:0] dur, input logic last,
                            input bit chk, input telem_t want);
    telem_t r;
    while (idle_on && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; pulse_level <= lvl; pulse_duration <= dur; is_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_pulse(lvl, dur, last, r)) begin
      if (chk && r != want)
        report_mismatch("typed row status and echo", {r.status, r.echo},
                        {want.status, want.echo});
      expected_q.push_back(r);
    end
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_PERIOD) period_q8 = val;
    else gap_min = val[14:0];
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // well-formed reply: echoes, gap, then 21 bit frame from a 16 bit word, optionally corrupted
  task automatic send_reply(input int echoes, input bit corrupt);
    logic [15:0] d16;
    logic [19:0] g;
    logic [20:0] v;
    logic [4:0] enc [16];
    int i, run, p;
    bit lv;
    logic [31:0] q;
    enc = '{5'h19, 5'h1B, 5'h12, 5'h13, 5'h1D, 5'h15, 5'h16, 5'h17,
            5'h1A, 5'h09, 5'h0A, 5'h0B, 5'h1E, 5'h0D, 5'h0E, 5'h0F};
    d16[15:4] = 12'($urandom);
    d16[3:0] = ~(d16[15:12] ^ d16[11:8] ^ d16[7:4]);
    if (corrupt) d16 ^= 16'(1 << $urandom_range(15));
    g = {enc[d16[15:12]], enc[d16[11:8]], enc[d16[7:4]], enc[d16[3:0]]};
    // leading one so that the first pulse after the gap is low
    v[20] = 1'b1;
    for (i = 19; i >= 0; i--) v[i] = v[i+1] ^ g[i];
    if (corrupt && $urandom_range(1)) v = 21'($urandom);
    for (i = 0; i < echoes; i++)
      send_pulse($urandom_range(1), 15'($urandom_range(1, gap_min > 1 ? gap_min - 1 : 1)),
                 1'b0, 0, '0);
    send_pulse(1'b1, 15'($urandom_range(gap_min, 32767)), 1'b0, 0, '0);
    q = period_q8;
    // runs of equal bits, msb first; bit value 1 is a low pulse
    p = 20;
    while (p >= 0) begin
      run = 0; lv = v[p];
      while (p >= 0 && v[p] == lv) begin run++; p--; end
      if (p < 0 && !lv && $urandom_range(1)) break;   // trailing zeros padded
      send_pulse(!lv, 15'((run * q + $urandom_range(0, q / 4)) / 256), 1'b0, 0, '0);
    end
    send_pulse($urandom_range(1), $urandom_range(3) == 0 ? 15'd0 : 15'($urandom),
               1'b1, 0, '0);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("dshot_telemetry_decoder_core_test NOT OK");
    $finish;
  end

  // result side
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b1;
    else out_stall <= idle_on && $urandom_range(99) < 22;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result word status", status, 0);
      end else begin
        telem_t w;
        w = expected_q.pop_front();
        if (status != w.status) report_mismatch("status", status, w.status);
        if (echo_pulses != w.echo) report_mismatch("echo_pulses", echo_pulses, w.echo);
        if (telem_kind != w.kind) report_mismatch("telem_kind", telem_kind, w.kind);
        if (period_us != w.period) report_mismatch("period_us", period_us, w.period);
        if (erpm != w.erpm) report_mismatch("erpm", erpm, w.erpm);
        if (edt_value != w.edt) report_mismatch("edt_value", edt_value, w.edt);
        n_results++;
      end
    end
  end

  initial begin
    row_t rows [20];
    int i, k;
    rst = 1'b1; cfg_we = 1'b0; cfg_index = CFG_PERIOD; cfg_data = '0;
    in_valid = 1'b0; pulse_level = 1'b0; pulse_duration = '0; is_last = 1'b0;
    errors = 0; n_results = 0; idle_on = 1'b1;
    period_q8 = 16'd27306; gap_min = 15'd332;
    clear_capture();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    rows = '{
      // lone end word: no reply
      '{1'b0, 15'd0, 1'b1, 1'b1, '{ST_NOREPLY, 7'd0, TK_NONE, 16'd0, 26'd0, 8'd0}},
      '{1'b1, 15'd100, 1'b1, 1'b1, '{ST_NOREPLY, 7'd1, TK_NONE, 16'd0, 26'd0, 8'd0}},
      // gap pulse as last: no reply
      '{1'b1, 15'd32767, 1'b1, 1'b1, '{ST_NOREPLY, 7'd0, TK_NONE, 16'd0, 26'd0, 8'd0}},
      // gap then high: framing
      '{1'b1, 15'd332, 1'b0, 1'b0, '0},
      '{1'b1, 15'd500, 1'b1, 1'b1, '{ST_FRAMING, 7'd0, TK_NONE, 16'd0, 26'd0, 8'd0}},
      // zero duration ends, then drained words
      '{1'b0, 15'd50, 1'b0, 1'b0, '0},
      '{1'b0, 15'd0, 1'b0, 1'b1, '{ST_NOREPLY, 7'd1, TK_NONE, 16'd0, 26'd0, 8'd0}},
      '{1'b1, 15'd400, 1'b0, 1'b0, '0},
      '{1'b0, 15'd7, 1'b1, 1'b0, '0},
      // gap then one long low: all ones frame, bad gcr
      '{1'b1, 15'd1000, 1'b0, 1'b0, '0},
      '{1'b0, 15'd32767, 1'b1, 1'b1, '{ST_BADGCR, 7'd0, TK_NONE, 16'd0, 26'd0, 8'd0}},
      // short low pulse rounds to one bit
      '{1'b1, 15'd1000, 1'b0, 1'b0, '0},
      '{1'b0, 15'd1, 1'b0, 1'b0, '0},
      '{1'b1, 15'd106, 1'b0, 1'b0, '0},
      '{1'b0, 15'd320, 1'b1, 1'b0, '0},
      '{1'b0, 15'd331, 1'b0, 1'b0, '0},
      '{1'b1, 15'd331, 1'b0, 1'b0, '0},
      '{1'b1, 15'd333, 1'b0, 1'b0, '0},
      '{1'b0, 15'd213, 1'b0, 1'b0, '0},
      '{1'b0, 15'd32767, 1'b1, 1'b0, '0}
    };
    for (i = 0; i < 20; i++)
      send_pulse(rows[i].level, rows[i].dur, rows[i].last, rows[i].chk, rows[i].res);
    // echo saturation and capture buffer overflow
    for (i = 0; i < 120; i++) send_pulse(1'b0, 15'(i + 1), 1'b0, 0, '0);
    send_pulse(1'b1, 15'd1, 1'b1, 0, '0);
    drain_results();

    for (k = 0; k < 7; k++) begin
      case (k)
        0: begin write_reg(CFG_PERIOD, 16'd27306); write_reg(CFG_GAP, 16'd332); end
        1: begin write_reg(CFG_PERIOD, 16'd1); write_reg(CFG_GAP, 16'd1); end
        2: begin write_reg(CFG_PERIOD, 16'd65535); write_reg(CFG_GAP, 16'd32767); end
        3: begin write_reg(CFG_PERIOD, 16'd0); write_reg(CFG_GAP, 16'd40); end
        4: begin
          write_reg(CFG_PERIOD, 16'($urandom_range(256, 8000)));
          write_reg(CFG_GAP, 16'($urandom_range(1, 32767)));
        end
        default: begin
          write_reg(CFG_PERIOD, 16'($urandom_range(256, 12000)));
          write_reg(CFG_GAP, 16'($urandom_range(200, 2000)));
        end
      endcase
      idle_on = (k != 5);
      i = 0;
      while (i < (k < 4 ? 90 : 240)) begin
        if (k >= 4 && $urandom_range(9) < 8) send_reply($urandom_range(0, 4), $urandom_range(5) == 0);
        else send_pulse($urandom_range(1), $urandom_range(7) == 0 ? 15'd0 : 15'($urandom),
                        $urandom_range(5) == 0, 0, '0);
        i += (k >= 4) ? 15 : 1;
        if (k == 6 && i == 120) begin
          // sender pause until every expected word is out
          in_valid <= 1'b0;
          while (expected_q.size() != 0) @(posedge clk);
        end
      end
      send_pulse(1'b0, 15'd0, 1'b1, 0, '0);
      drain_results();
    end

    if (errors == 0) $display("dshot_telemetry_decoder_core_test OK");
    else $display("dshot_telemetry_decoder_core_test NOT OK");
    $finish;
  end
endmodule
